@@ rtl/imh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg: shared types and constants for the indexed min-heap core
// Widths, status codes, sequencer states, payload structs and helpers.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int CAPACITY   = 256;
    localparam int KEY_W      = 8;
    localparam int COST_W     = 31;
    localparam int NUM_KEYS   = 1 << KEY_W;
    localparam int POS_W      = $clog2(CAPACITY + 1);
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int SLOT_W     = KEY_W + COST_W;
    localparam int COUNT_W    = 9;
    localparam int CLR_W      = $clog2(NUM_KEYS);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_IGNORED  = 2'd3
    } status_t;

    localparam logic FUNC_INSERT  = 1'b0;
    localparam logic FUNC_EXTRACT = 1'b1;

    typedef struct packed {
        logic              func;
        logic [KEY_W-1:0]  key_id;
        logic [COST_W-1:0] cost;
    } in_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   out_key;
        logic [COST_W-1:0]  out_cost;
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
    } out_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [COST_W-1:0] cost;
    } slot_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_UP_RD,
        S_UP_CMP,
        S_EX_ROOT,
        S_EX_LAST,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_DONE
    } state_t;

    // Lower cost first, equal cost: larger key first.
    function automatic logic goes_first(input slot_t a, input slot_t b);
        if (a.cost == b.cost) begin
            return a.key > b.key;
        end
        return a.cost < b.cost;
    endfunction

endpackage

@@ rtl/indexed_min_heap_decrease_key_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_core: indexed binary min-heap
// Insert / decrease-key and extract-min over a slot RAM and a position RAM.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data  (func, key_id, cost)
//  m_      | out       | m_valid / m_ready  | m_data  (out_key, out_cost, status, count)
//
// An insert looks up the key's position, reads its slot, then reads and compares
// one parent per level climbed; an extract reads the root and the last entry, then
// reads both children and compares per level descended, on the single port of the
// slot RAM, one access a cycle. After reset a clearing pass zeroes the position
// table; s_ready stays low meanwhile. A result waits in the output register until
// taken; the next transaction is accepted once the result register is free.
module indexed_min_heap_decrease_key_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  imh_pkg::in_item_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output imh_pkg::out_item_t m_data
);
    import imh_pkg::*;

    state_t state_reg, state_next;
    in_item_t item_reg, item_next;
    logic [POS_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0] p_reg, p_next;       // current slot of the moving entry
    logic [POS_W-1:0] q_reg, q_next;       // slot of best child
    slot_t cur_reg, cur_next;              // moving entry
    slot_t best_reg, best_next;
    logic [CLR_W-1:0] clr_reg, clr_next;
    logic [1:0] st_reg, st_next;
    out_item_t res_reg, res_next;
    logic m_valid_reg, m_valid_next;

    // Slot RAM port (slot s lives at address s-1).
    logic s_we;
    logic [POS_W-1:0] s_slot;
    slot_t s_wdata, s_rdata;
    // Position RAM port.
    logic k_we;
    logic [KEY_W-1:0] k_addr;
    logic [POS_W-1:0] k_wdata, k_rdata;

    logic [ADDR_W-1:0] s_addr;
    assign s_addr = ADDR_W'(s_slot - POS_W'(1));

    imh_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slots (
        .aclk(aclk), .we(s_we), .addr(s_addr), .wdata(s_wdata), .rdata(s_rdata)
    );
    imh_ram #(.WIDTH(POS_W), .DEPTH(NUM_KEYS)) u_pos (
        .aclk(aclk), .we(k_we), .addr(k_addr), .wdata(k_wdata), .rdata(k_rdata)
    );

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            cnt_reg     <= '0;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
        end
        item_reg <= item_next;
        p_reg    <= p_next;
        q_reg    <= q_next;
        cur_reg  <= cur_next;
        best_reg <= best_next;
        st_reg   <= st_next;
        res_reg  <= res_next;
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        cnt_next     = cnt_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        cur_next     = cur_reg;
        best_next    = best_reg;
        clr_next     = clr_reg;
        st_next      = st_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_we    = 1'b0;
        s_slot  = p_reg;
        s_wdata = cur_reg;
        k_we    = 1'b0;
        k_addr  = cur_reg.key;
        k_wdata = p_reg;

        case (state_reg)
            S_CLEAR: begin
                k_we     = 1'b1;
                k_addr   = clr_reg;
                k_wdata  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == {CLR_W{1'b1}}) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_slot = POS_W'(1);
                k_addr = s_data.key_id;
                if (s_valid && s_ready) begin
                    item_next = s_data;
                    st_next   = ST_OK;
                    if (s_data.func == FUNC_EXTRACT) begin
                        if (cnt_reg == '0) begin
                            st_next    = ST_EMPTY;
                            state_next = S_DONE;
                        end else begin
                            state_next = S_EX_ROOT;
                        end
                    end else begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            // Position of the key is now on k_rdata; fetch its slot.
            S_LOOKUP: begin
                s_slot = k_rdata;
                p_next = k_rdata;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (p_reg == '0) begin
                    if (cnt_reg == POS_W'(CAPACITY)) begin
                        st_next    = ST_FULL;
                        state_next = S_DONE;
                    end else begin
                        cnt_next      = cnt_reg + 1'b1;
                        p_next        = cnt_reg + 1'b1;
                        cur_next.key  = item_reg.key_id;
                        cur_next.cost = item_reg.cost;
                        state_next    = S_UP_RD;
                    end
                end else if (p_reg <= cnt_reg && item_reg.cost < s_rdata.cost) begin
                    cur_next.key  = item_reg.key_id;
                    cur_next.cost = item_reg.cost;
                    state_next    = S_UP_RD;
                end else begin
                    st_next    = ST_IGNORED;
                    state_next = S_DONE;
                end
            end
            // Moving entry belongs at p (not yet written); read its parent.
            S_UP_RD: begin
                if (p_reg > POS_W'(1)) begin
                    s_slot     = p_reg >> 1;
                    state_next = S_UP_CMP;
                end else begin
                    s_we       = 1'b1;
                    k_we       = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_UP_CMP: begin
                if (goes_first(cur_reg, s_rdata)) begin
                    // Parent moves down into slot p.
                    s_we       = 1'b1;
                    s_wdata    = s_rdata;
                    k_we       = 1'b1;
                    k_addr     = s_rdata.key;
                    p_next     = p_reg >> 1;
                    state_next = S_UP_RD;
                end else begin
                    s_we       = 1'b1;
                    k_we       = 1'b1;
                    state_next = S_DONE;
                end
            end
            // Root data arrives; clear its position and read the last entry.
            S_EX_ROOT: begin
                res_next.out_key  = s_rdata.key;
                res_next.out_cost = s_rdata.cost;
                k_we       = 1'b1;
                k_addr     = s_rdata.key;
                k_wdata    = '0;
                s_slot     = cnt_reg;
                cnt_next   = cnt_reg - 1'b1;
                p_next     = POS_W'(1);
                state_next = S_EX_LAST;
            end
            S_EX_LAST: begin
                cur_next = s_rdata;
                if (cnt_reg == '0) begin
                    state_next = S_DONE;
                end else begin
                    state_next = S_DN_RDL;
                end
            end
            S_DN_RDL: begin
                if ({1'b0, p_reg} << 1 <= {1'b0, cnt_reg}) begin
                    s_slot     = POS_W'({1'b0, p_reg} << 1);
                    state_next = S_DN_RDR;
                end else begin
                    s_we       = 1'b1;
                    k_we       = 1'b1;
                    state_next = S_DONE;
                end
            end
            // Left child is on s_rdata; keep it while the right one is read.
            S_DN_RDR: begin
                best_next  = s_rdata;
                q_next     = POS_W'({1'b0, p_reg} << 1);
                s_slot     = POS_W'(({1'b0, p_reg} << 1) + 1'b1);
                state_next = S_DN_CMP;
            end
            S_DN_CMP: begin
                if (q_reg + 1'b1 <= cnt_reg && goes_first(s_rdata, best_reg)) begin
                    best_next = s_rdata;
                    q_next    = q_reg + 1'b1;
                end
                if ((q_reg + 1'b1 <= cnt_reg && goes_first(s_rdata, best_reg)
                        && goes_first(s_rdata, cur_reg))) begin
                    s_we    = 1'b1;
                    s_wdata = s_rdata;
                    k_we    = 1'b1;
                    k_addr  = s_rdata.key;
                    p_next  = q_reg + 1'b1;
                    state_next = S_DN_RDL;
                end else if (goes_first(best_reg, cur_reg)) begin
                    s_we    = 1'b1;
                    s_wdata = best_reg;
                    k_we    = 1'b1;
                    k_addr  = best_reg.key;
                    p_next  = q_reg;
                    state_next = S_DN_RDL;
                end else begin
                    s_we       = 1'b1;
                    k_we       = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!(item_reg.func == FUNC_EXTRACT && st_reg == ST_OK)) begin
                    res_next.out_key  = '0;
                    res_next.out_cost = '0;
                end
                res_next.status = st_reg;
                res_next.count  = COUNT_W'(cnt_reg);
                m_valid_next    = 1'b1;
                state_next      = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

@@ rtl/imh_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/imh_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_checker: port-level assertions for the heap core
// Watches the two channels and the reported status and count.
// ----------------------------------------------------------------------------
module imh_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input imh_pkg::out_item_t m_data
);
    import imh_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted during work");

    a_no_ready_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input ready while a result is pending");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.count <= COUNT_W'(CAPACITY))
        else $error("count beyond capacity");

    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.out_key == '0
            && m_data.out_cost == '0)
        else $error("nonzero pair on a failed transaction");
endmodule

bind indexed_min_heap_decrease_key_core imh_checker u_imh_checker (.*);

@@ verif/tb_indexed_min_heap_decrease_key_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_decrease_key_core: self-checking bench for the heap core
// Drives insert, decrease-key and extract transactions under varied idling and
// back-pressure, and checks each result against a heap kept in the bench.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_decrease_key_core;
    import imh_pkg::*;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    indexed_min_heap_decrease_key_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Heap mirror: slots 1..heap_size, key_slot[k] = 0 when k is absent.
    logic [KEY_W-1:0]  slot_key  [1:CAPACITY];
    logic [COST_W-1:0] slot_cost [1:CAPACITY];
    int unsigned       key_slot  [NUM_KEYS];
    int unsigned       heap_size;

    out_item_t pending_results[$];
    int        mismatches;
    int        idle_pct;
    int        stall_pct;
    int        hold_off;

    function automatic bit ranks_higher(int unsigned a, int unsigned b);
        if (slot_cost[a] == slot_cost[b]) begin
            return slot_key[a] > slot_key[b];
        end
        return slot_cost[a] < slot_cost[b];
    endfunction

    function automatic void swap_slots(int unsigned a, int unsigned b);
        logic [KEY_W-1:0]  k;
        logic [COST_W-1:0] c;
        k = slot_key[a];
        c = slot_cost[a];
        slot_key[a]  = slot_key[b];
        slot_cost[a] = slot_cost[b];
        slot_key[b]  = k;
        slot_cost[b] = c;
        key_slot[slot_key[a]] = a;
        key_slot[slot_key[b]] = b;
    endfunction

    function automatic void climb(int unsigned p);
        while (p > 1 && ranks_higher(p, p / 2)) begin
            swap_slots(p, p / 2);
            p = p / 2;
        end
    endfunction

    function automatic void descend(int unsigned p);
        int unsigned best;
        while (2 * p <= heap_size) begin
            best = p;
            if (ranks_higher(2 * p, best)) best = 2 * p;
            if (2 * p + 1 <= heap_size && ranks_higher(2 * p + 1, best)) best = 2 * p + 1;
            if (best == p) break;
            swap_slots(p, best);
            p = best;
        end
    endfunction

    function automatic out_item_t apply_to_heap(in_item_t it);
        out_item_t   r;
        int unsigned p;
        r = '0;
        r.status = ST_OK;
        if (it.func == FUNC_EXTRACT) begin
            if (heap_size == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.out_key  = slot_key[1];
                r.out_cost = slot_cost[1];
                key_slot[slot_key[1]] = 0;
                if (heap_size > 1) begin
                    slot_key[1]  = slot_key[heap_size];
                    slot_cost[1] = slot_cost[heap_size];
                    key_slot[slot_key[1]] = 1;
                end
                heap_size--;
                descend(1);
            end
        end else begin
            p = key_slot[it.key_id];
            if (p == 0) begin
                if (heap_size >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    heap_size++;
                    slot_key[heap_size]  = it.key_id;
                    slot_cost[heap_size] = it.cost;
                    key_slot[it.key_id] = heap_size;
                    climb(heap_size);
                end
            end else if (it.cost < slot_cost[p]) begin
                slot_cost[p] = it.cost;
                climb(p);
            end else begin
                r.status = ST_IGNORED;
            end
        end
        r.count = COUNT_W'(heap_size);
        return r;
    endfunction

    // Offer one transaction; the valid stays high on return so that a
    // back-to-back transaction never lowers and raises it in one step.
    task automatic send_item(logic func, logic [KEY_W-1:0] key, logic [COST_W-1:0] cost);
        in_item_t it;
        bit       taken;
        it.func   = func;
        it.key_id = key;
        it.cost   = cost;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do begin
            @(negedge aclk);
            taken = s_ready;
            @(posedge aclk);
        end while (!taken);
        pending_results.push_back(apply_to_heap(it));
    endtask

    task automatic drain_results();
        if (s_valid) s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        case ($urandom_range(3))
            0:       return COST_W'($urandom_range(15));
            1:       return {COST_W{1'b1}} - COST_W'($urandom_range(3));
            default: return COST_W'($urandom());
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready  <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(negedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected transaction: %p", m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.out_key !== want.out_key || m_data.out_cost !== want.out_cost ||
                    m_data.status !== want.status || m_data.count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Mismatch: expected key %0d cost %0d status %0d count %0d,",
                                 want.out_key, want.out_cost, want.status, want.count);
                        $display("          got      key %0d cost %0d status %0d count %0d",
                                 m_data.out_key, m_data.out_cost, m_data.status, m_data.count);
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_item(FUNC_EXTRACT, 8'd0, '0);
        send_item(FUNC_INSERT, 8'd0, {COST_W{1'b1}});
        send_item(FUNC_INSERT, 8'd255, '0);
        send_item(FUNC_INSERT, 8'd17, 31'd100);
        send_item(FUNC_INSERT, 8'd18, 31'd100);
        send_item(FUNC_INSERT, 8'd16, 31'd100);
        send_item(FUNC_INSERT, 8'd17, 31'd100);
        send_item(FUNC_INSERT, 8'd16, 31'd200);
        send_item(FUNC_INSERT, 8'd0, 31'd50);
        send_item(FUNC_INSERT, 8'd0, '0);
        send_item(FUNC_INSERT, 8'd170, 31'h2AAAAAAA);
        send_item(FUNC_INSERT, 8'd85, 31'h55555555);
        repeat (9) send_item(FUNC_EXTRACT, 8'd255, {COST_W{1'b1}});
        send_item(FUNC_INSERT, 8'd5, 31'd7);
        send_item(FUNC_EXTRACT, 8'd0, '0);
        send_item(FUNC_INSERT, 8'd5, 31'd9);
        send_item(FUNC_EXTRACT, 8'd0, '0);
        drain_results();
    endtask

    // Keeps the heap near 40 entries, with decreases on a narrow key range.
    task automatic test_random_mix(int n);
        logic [KEY_W-1:0] key;
        repeat (n) begin
            key = ($urandom_range(1)) ? KEY_W'($urandom_range(31)) : KEY_W'($urandom_range(255));
            if ($urandom_range(99) < ((heap_size > 40) ? 60 : 30)) begin
                send_item(FUNC_EXTRACT, KEY_W'($urandom_range(255)), COST_W'($urandom()));
            end else begin
                send_item(FUNC_INSERT, key, pick_cost());
            end
        end
        drain_results();
    endtask

    // Every key in, some decreases at full size, then empty it again.
    task automatic test_fill_and_drain();
        int order[NUM_KEYS];
        foreach (order[i]) order[i] = i;
        order.shuffle();
        foreach (order[i]) send_item(FUNC_INSERT, KEY_W'(order[i]), pick_cost());
        repeat (20) send_item(FUNC_INSERT, KEY_W'($urandom_range(255)),
                              COST_W'($urandom_range(15)));
        repeat (CAPACITY + 2) send_item(FUNC_EXTRACT, '0, '0);
        drain_results();
    endtask

    task automatic test_backpressure();
        hold_off = 400;
        repeat (30) send_item(FUNC_INSERT, KEY_W'($urandom_range(255)), pick_cost());
        repeat (30) send_item(FUNC_EXTRACT, '0, '0);
        drain_results();
    endtask

    initial begin
        mismatches = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        hold_off   = 0;
        heap_size  = 0;
        foreach (key_slot[i]) key_slot[i] = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        idle_pct = 0;  stall_pct = 0;  test_random_mix(200);
        idle_pct = 81; stall_pct = 0;  test_random_mix(150);
        idle_pct = 0;  stall_pct = 81; test_random_mix(150);
        idle_pct = 22; stall_pct = 22; test_random_mix(150);
        idle_pct = 22; stall_pct = 22; test_fill_and_drain();
        idle_pct = 0;  stall_pct = 0;  test_backpressure();

        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
